[rtl/varint_byte_stream_codec_macros.svh]
// Assertion macros shared by the varint byte stream codec.
`ifndef VARINT_BYTE_STREAM_CODEC_MACROS_SVH
`define VARINT_BYTE_STREAM_CODEC_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define VBSC_ASSERT_SAME(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define VBSC_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/vbsc_pkg.sv]
// Shared types, constants and the frame magic table of the varint byte stream codec.
`timescale 1ns / 1ps

package vbsc_pkg;

  localparam logic [3:0] MAGIC_LEN  = 4'd9;
  localparam logic [2:0] MAX_GROUPS = 3'd6;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_MAGIC = 3'd1,
    ST_OVERLONG  = 3'd2,
    ST_TOO_BIG   = 3'd3,
    ST_TRAILING  = 3'd4,
    ST_TRUNCATED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_MAGIC   = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        last;
    logic [31:0] frame_length;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_end;
    logic [2:0] status;
  } out_word_t;

  // One classified input word: the pieces of output the back end must produce for it.
  typedef struct packed {
    logic        hdr;     // magic followed by the length varint
    logic [31:0] length;
    logic        enc;     // data as a varint
    logic        dec;     // data as a plain decoded byte
    logic [7:0]  data;
    logic        stat;    // status-only word
    status_t     status;
    logic        last;    // the final word produced carries frame_end
  } job_t;

  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] b;
    unique case (idx)
      4'd0:    b = 8'h42;
      4'd1:    b = 8'h5A;
      4'd2:    b = 8'h56;
      4'd3:    b = 8'h42;
      4'd4:    b = 8'h59;
      4'd5:    b = 8'h54;
      4'd6:    b = 8'h45;
      4'd7:    b = 8'h31;
      4'd8:    b = 8'h0A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

[rtl/vbsc_queue.sv]
// Small register queue of classified jobs between the front and back ends.
`timescale 1ns / 1ps

module vbsc_queue
  import vbsc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_data,
  output logic full,
  input  logic rd_en,
  output job_t rd_data,
  output logic empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/vbsc_front.sv]
// Front end: accepts input words, tracks framing, runs the decoder and classifies each word.
`timescale 1ns / 1ps

module vbsc_front
  import vbsc_pkg::*;
#(
  parameter int LENGTH_BITS = 32
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_word_t in_word,
  output logic     full,
  input  logic     direction,
  input  logic     job_full,
  output logic     job_push,
  output job_t     job
);

  logic                   in_frame;
  phase_t                 phase;
  logic [3:0]             magic_idx;
  logic [31:0]            acc;
  logic [2:0]             group_cnt;
  logic [LENGTH_BITS-1:0] remaining;
  status_t                err;

  logic                   in_frame_next;
  phase_t                 phase_next;
  logic [3:0]             magic_idx_next;
  logic [31:0]            acc_next;
  logic [2:0]             group_cnt_next;
  logic [LENGTH_BITS-1:0] remaining_next;
  status_t                err_next;

  logic                   accept;
  logic                   dec_emit;
  logic [7:0]             dec_value;
  logic [31:0]            acc_or;
  logic [31:0]            acc_new;
  logic                   enc_dir;
  status_t                end_status;

  assign full    = job_full;
  assign accept  = push && !job_full;
  assign enc_dir = (direction == DIR_ENCODE);

  always_comb begin : decode_next
    in_frame_next  = in_frame;
    phase_next     = phase;
    magic_idx_next = magic_idx;
    acc_next       = acc;
    group_cnt_next = group_cnt;
    remaining_next = remaining;
    err_next       = err;
    dec_emit       = 1'b0;
    dec_value      = 8'd0;
    acc_or         = 32'd0;
    acc_new        = 32'd0;
    if (accept) begin
      in_frame_next = !in_word.last;
      if (!in_frame) begin
        phase_next     = PH_MAGIC;
        magic_idx_next = 4'd0;
        acc_next       = 32'd0;
        group_cnt_next = 3'd0;
        remaining_next = '0;
        err_next       = ST_OK;
      end
      if (!enc_dir && in_word.has_byte && err_next == ST_OK) begin
        unique case (phase_next)
          PH_MAGIC: begin
            if (magic_idx_next >= MAGIC_LEN ||
                in_word.data_byte != magic_byte(magic_idx_next)) begin
              err_next = ST_BAD_MAGIC;
            end else begin
              magic_idx_next = magic_idx_next + 4'd1;
              if (magic_idx_next == MAGIC_LEN) begin
                phase_next = PH_LENGTH;
              end
            end
          end
          PH_DONE: begin
            err_next = ST_TRAILING;
          end
          PH_LENGTH, PH_PAYLOAD: begin
            // Groups past the fifth would land above bit 31 and are dropped.
            if (group_cnt_next <= 3'd4) begin
              acc_or = {25'd0, in_word.data_byte[6:0]} << (6'(group_cnt_next) * 6'd7);
            end
            acc_new = acc_next | acc_or;
            if (in_word.data_byte[7]) begin
              acc_next       = acc_new;
              group_cnt_next = group_cnt_next + 3'd1;
              if (group_cnt_next >= MAX_GROUPS) begin
                err_next = ST_OVERLONG;
              end
            end else begin
              acc_next       = 32'd0;
              group_cnt_next = 3'd0;
              if (phase_next == PH_LENGTH) begin
                remaining_next = acc_new[LENGTH_BITS-1:0];
                phase_next     = (remaining_next == '0) ? PH_DONE : PH_PAYLOAD;
              end else if (acc_new[31:8] != 24'd0) begin
                err_next = ST_TOO_BIG;
              end else begin
                dec_emit       = 1'b1;
                dec_value      = acc_new[7:0];
                remaining_next = remaining_next - 1'b1;
                if (remaining_next == '0) begin
                  phase_next = PH_DONE;
                end
              end
            end
          end
        endcase
      end
    end
  end

  always_comb begin : job_build
    end_status = err_next;
    if (err_next == ST_OK) begin
      if (phase_next == PH_MAGIC) begin
        end_status = ST_BAD_MAGIC;
      end else if (phase_next != PH_DONE || group_cnt_next != 3'd0) begin
        end_status = ST_TRUNCATED;
      end
    end
    job.hdr    = enc_dir && !in_frame;
    job.length = 32'(in_word.frame_length[LENGTH_BITS-1:0]);
    job.enc    = enc_dir && in_word.has_byte;
    job.dec    = !enc_dir && dec_emit;
    job.data   = enc_dir ? in_word.data_byte : dec_value;
    job.stat   = in_word.last && (enc_dir ? (in_frame && !in_word.has_byte) : 1'b1);
    job.status = enc_dir ? ST_OK : end_status;
    job.last   = in_word.last;
    job_push   = accept && (job.hdr || job.enc || job.dec || job.stat);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame  <= 1'b0;
      phase     <= PH_MAGIC;
      magic_idx <= 4'd0;
      acc       <= 32'd0;
      group_cnt <= 3'd0;
      remaining <= '0;
      err       <= ST_OK;
    end else begin
      in_frame  <= in_frame_next;
      phase     <= phase_next;
      magic_idx <= magic_idx_next;
      acc       <= acc_next;
      group_cnt <= group_cnt_next;
      remaining <= remaining_next;
      err       <= err_next;
    end
  end

endmodule

[rtl/vbsc_back.sv]
// Back end: queued jobs become result words in an output register, one a cycle if no stall.
`timescale 1ns / 1ps

module vbsc_back
  import vbsc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      job_valid,
  input  job_t      job,
  output logic      job_pop,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word
);

  typedef enum logic [2:0] {
    SEG_MAGIC = 3'd0,
    SEG_LEN   = 3'd1,
    SEG_ENC   = 3'd2,
    SEG_DEC   = 3'd3,
    SEG_STAT  = 3'd4,
    SEG_NONE  = 3'd5
  } seg_t;

  logic        started;
  seg_t        seg;
  logic [3:0]  magic_idx;
  logic [31:0] value;
  logic        out_valid;

  logic        started_next;
  seg_t        seg_next;
  logic [3:0]  magic_idx_next;
  logic [31:0] value_next;

  seg_t        cur_seg;
  seg_t        after_seg;
  logic [3:0]  cur_midx;
  logic [31:0] cur_val;
  logic        step;
  logic        seg_done;
  logic        job_done;
  out_word_t   emit;

  function automatic seg_t first_seg(input job_t j);
    seg_t s;
    priority if (j.hdr) s = SEG_MAGIC;
    else if (j.enc)     s = SEG_ENC;
    else if (j.dec)     s = SEG_DEC;
    else if (j.stat)    s = SEG_STAT;
    else                s = SEG_NONE;
    return s;
  endfunction

  function automatic seg_t seg_after(input job_t j, input seg_t s);
    seg_t n;
    logic enc_ok;
    logic dec_ok;
    logic stat_ok;
    enc_ok  = (s == SEG_MAGIC || s == SEG_LEN) && j.enc;
    dec_ok  = (s == SEG_MAGIC || s == SEG_LEN || s == SEG_ENC) && j.dec;
    stat_ok = (s != SEG_STAT && s != SEG_NONE) && j.stat;
    priority if (s == SEG_MAGIC) n = SEG_LEN;
    else if (enc_ok)            n = SEG_ENC;
    else if (dec_ok)            n = SEG_DEC;
    else if (stat_ok)           n = SEG_STAT;
    else                        n = SEG_NONE;
    return n;
  endfunction

  assign cur_seg   = started ? seg : first_seg(job);
  assign cur_midx  = started ? magic_idx : 4'd0;
  assign cur_val   = started ? value : {24'd0, job.data};
  assign after_seg = seg_after(job, cur_seg);
  assign step      = job_valid && (!out_valid || pop);
  assign empty     = !out_valid;

  always_comb begin : seg_output
    emit.out_byte   = 8'd0;
    emit.byte_valid = 1'b1;
    emit.status     = ST_OK;
    seg_done        = 1'b1;
    unique case (cur_seg)
      SEG_MAGIC: begin
        emit.out_byte = magic_byte(cur_midx);
        seg_done      = (cur_midx == MAGIC_LEN - 4'd1);
      end
      SEG_LEN, SEG_ENC: begin
        seg_done      = (cur_val[31:7] == 25'd0);
        emit.out_byte = {!seg_done, cur_val[6:0]};
      end
      SEG_DEC: begin
        emit.out_byte = job.data;
      end
      SEG_STAT: begin
        emit.byte_valid = 1'b0;
        emit.status     = job.status;
      end
      default: begin
        emit.byte_valid = 1'b0;
      end
    endcase
    job_done       = seg_done && (after_seg == SEG_NONE);
    emit.frame_end = job.last && job_done;
    job_pop        = step && job_done;
  end

  always_comb begin : seg_next_state
    started_next   = started;
    seg_next       = seg;
    magic_idx_next = magic_idx;
    value_next     = value;
    if (step) begin
      if (job_done) begin
        started_next = 1'b0;
      end else if (seg_done) begin
        started_next   = 1'b1;
        seg_next       = after_seg;
        magic_idx_next = 4'd0;
        value_next     = (after_seg == SEG_LEN) ? job.length : {24'd0, job.data};
      end else begin
        started_next   = 1'b1;
        seg_next       = cur_seg;
        magic_idx_next = cur_midx + 4'd1;
        value_next     = {7'd0, cur_val[31:7]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      seg       <= SEG_NONE;
      magic_idx <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      started   <= started_next;
      seg       <= seg_next;
      magic_idx <= magic_idx_next;
      if (step) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    if (step) begin
      out_word <= emit;
    end
  end

endmodule

[rtl/varint_byte_stream_codec.sv]
// Top level of the varint byte stream codec: front end, job queue, back end and register port.
//
//   Channel   Handshake              Payload        Direction
//   input     push / full            in_word_t      into the block
//   result    pop / empty            out_word_t     out of the block
//   config    psel/penable/pwrite    pwdata/prdata  APB, one register (direction)
//
// The back end puts out one result word per cycle while a job waits and the result register
// is empty or popped; a frame header is 9 magic bytes plus a 1 to 5 byte length varint, an
// encoded payload byte 1 or 2 bytes, and a decode word 0 or 1 word (two when a payload byte
// and the status word fall together). The front end takes one input word per cycle while the
// job queue has room; the single byte-wide result register is what sets the sustained rate.
// Reset is synchronous and active high; it closes any open frame and empties both sides.
// A stall on the result side fills the job queue and only then raises full.
`timescale 1ns / 1ps

`include "varint_byte_stream_codec_macros.svh"

module varint_byte_stream_codec
  import vbsc_pkg::*;
#(
  parameter int LENGTH_BITS = 32,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  // Input word channel.
  input  logic        push,
  output logic        full,
  input  in_word_t    in_word,
  // Result word channel.
  output logic        empty,
  input  logic        pop,
  output out_word_t   out_word,
  // Register port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic REG_DIRECTION = 1'b0;

  logic direction;
  logic reg_index;
  logic reg_write;

  job_t front_job;
  job_t head_job;
  logic job_push;
  logic job_full;
  logic job_empty;
  logic job_pop;

  // Register i sits at byte address 4*i; the low two address bits pick a byte lane and
  // are not decoded.
  assign reg_index = 1'(paddr >> 2);
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready;
  assign prdata    = (reg_index == REG_DIRECTION) ? {31'd0, direction} : 32'd0;

  // Direction applies to the next accepted word; only change it when idle (not enforced).
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
    end else if (reg_write && reg_index == REG_DIRECTION) begin
      direction <= pwdata[0];
    end
  end

  // The front end owns all framing and decoder state, so it never waits on the back end
  // except through the queue's full flag.
  vbsc_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_word   (in_word),
    .full      (full),
    .direction (direction),
    .job_full  (job_full),
    .job_push  (job_push),
    .job       (front_job)
  );

  vbsc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (front_job),
    .full    (job_full),
    .rd_en   (job_pop),
    .rd_data (head_job),
    .empty   (job_empty)
  );

  // The back end walks the head job segment by segment and retires it with its final word.
  vbsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!job_empty),
    .job       (head_job),
    .job_pop   (job_pop),
    .empty     (empty),
    .pop       (pop),
    .out_word  (out_word)
  );

  // A job is never offered to a full queue.
  `VBSC_ASSERT_SAME(a_no_push_when_full, clk, rst, job_push, !job_full, "job pushed into full queue")

  // A pushed job is waiting for the back end in the following cycle.
  `VBSC_ASSERT_NEXT(a_push_fills_queue, clk, rst, job_push, !job_empty, "pushed job went missing")

  // A fault is only ever reported on the status word that closes a frame.
  `VBSC_ASSERT_SAME(a_status_on_end_word, clk, rst, !empty && out_word.status != ST_OK, !out_word.byte_valid && out_word.frame_end, "fault reported on a data word")

  // A status-only word carries a zero byte.
  `VBSC_ASSERT_SAME(a_idle_byte_zero, clk, rst, !empty && !out_word.byte_valid, out_word.out_byte == 8'd0, "status word carries data")

endmodule
